>>> rtl/psc_pkg.sv
// Shared constants, types and request struct for the parity substring counter.
package psc_pkg;

  localparam int NUM_LETTERS  = 10;
  localparam int MAX_WORD_LEN = 65536;

  localparam int LETTER_W   = 4;
  localparam int MASK_W     = NUM_LETTERS;
  localparam int HIST_DEPTH = 1 << MASK_W;
  localparam int CNT_W      = $clog2(MAX_WORD_LEN + 2);
  localparam int TOTAL_W    = 32;
  localparam int EPOCH_W    = 8;
  localparam int IDX_W      = $clog2(NUM_LETTERS + 1);

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [MASK_W-1:0]   mask_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [TOTAL_W-1:0]  total_t;
  typedef logic [EPOCH_W-1:0]  epoch_t;
  typedef logic [IDX_W-1:0]    idx_t;

  localparam cnt_t   HIST_MAX  = '1;
  localparam epoch_t EPOCH_MAX = '1;
  localparam epoch_t EPOCH_CLR = '0;
  localparam epoch_t EPOCH_1ST = epoch_t'(1);

  // One histogram stored word: word tag plus count.
  typedef struct packed {
    epoch_t tag;
    cnt_t   cnt;
  } hist_word_t;

  // Histogram port request from the sequencer.
  typedef struct packed {
    logic       rd_en;
    logic       wr_en;
    mask_t      addr;
    hist_word_t wr_word;
  } hist_req_t;

endpackage

>>> rtl/parity_substring_counter_unit.sv
// Top level: sequencer, mask and total registers of the parity substring counter.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------
//  in      | request   | in_valid / in_stall   | in_letter[3:0], in_new_word
//  out     | result    | out_valid / out_stall | out_running_count[31:0]
//
// Each request passes through these steps: take it, NUM_LETTERS+1 histogram reads
// on the single memory port, fold in the last read, one write-back.
// After reset a clearing pass over all 1024 histogram entries runs before
// in_stall drops; the same pass runs again on every 255th new word, when
// the 8-bit word tag wraps. A result waiting on out_stall holds the write-back,
// so the next request is taken only once the output register is free.
module parity_substring_counter_unit
  import psc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  letter_t in_letter,
  input  logic    in_new_word,
  output logic    out_valid,
  input  logic    out_stall,
  output total_t  out_running_count
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_WRITE
  } state_t;

  state_t    state_r, state_nxt;
  mask_t     mask_r, mask_nxt;
  total_t    total_r, total_nxt;
  epoch_t    epoch_r, epoch_nxt;
  idx_t      idx_r, idx_nxt;
  mask_t     clr_idx_r, clr_idx_nxt;
  logic      pending_r, pending_nxt;
  logic      acc_vld_r, acc_vld_nxt;
  logic      acc_first_r, acc_first_nxt;
  cnt_t      self_cnt_r, self_cnt_nxt;
  logic      out_valid_r, out_valid_nxt;
  total_t    out_count_r, out_count_nxt;

  hist_req_t hist_req;
  cnt_t      hist_value;
  total_t    acc_sum;
  mask_t     base_mask;
  logic      letter_ok;

  psc_hist u_hist (
    .clk      (clk),
    .req      (hist_req),
    .epoch    (epoch_r),
    .rd_value (hist_value)
  );

  psc_accum u_accum (
    .total_i  (total_r),
    .addend_i (hist_value),
    .sum_o    (acc_sum)
  );

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_running_count = out_count_r;

  // Codes at or above NUM_LETTERS toggle no parity bit.
  assign letter_ok = ({1'b0, in_letter} < (LETTER_W + 1)'(NUM_LETTERS));
  assign base_mask = in_new_word ? '0 : mask_r;

  always_comb begin
    state_nxt     = state_r;
    mask_nxt      = mask_r;
    total_nxt     = total_r;
    epoch_nxt     = epoch_r;
    idx_nxt       = idx_r;
    clr_idx_nxt   = clr_idx_r;
    pending_nxt   = pending_r;
    acc_vld_nxt   = 1'b0;
    acc_first_nxt = 1'b0;
    self_cnt_nxt  = self_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_count_nxt = out_count_r;
    hist_req      = '0;

    // Fold in the read issued last cycle.
    if (acc_vld_r) begin
      total_nxt = acc_sum;
      if (acc_first_r) begin
        self_cnt_nxt = hist_value;
      end
    end

    unique case (state_r)
      S_CLEAR: begin
        // Sweep every entry to the cleared tag.
        hist_req.wr_en       = 1'b1;
        hist_req.addr        = clr_idx_r;
        hist_req.wr_word.tag = EPOCH_CLR;
        hist_req.wr_word.cnt = '0;
        clr_idx_nxt          = clr_idx_r + mask_t'(1);
        if (clr_idx_r == '1) begin
          state_nxt   = pending_r ? S_READ : S_IDLE;
          pending_nxt = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          mask_nxt = letter_ok ? (base_mask ^ (mask_t'(1) << in_letter)) : base_mask;
          idx_nxt  = '0;
          state_nxt = S_READ;
          if (in_new_word) begin
            total_nxt = '0;
            if (epoch_r == EPOCH_MAX) begin
              // Tag wraps: sweep the histogram before reading.
              epoch_nxt   = EPOCH_1ST;
              pending_nxt = 1'b1;
              state_nxt   = S_CLEAR;
            end else begin
              epoch_nxt = epoch_r + epoch_t'(1);
            end
          end
        end
      end
      S_READ: begin
        hist_req.rd_en = 1'b1;
        hist_req.addr  = (idx_r == '0) ? mask_r
                                       : (mask_r ^ (mask_t'(1) << (idx_r - idx_t'(1))));
        acc_vld_nxt    = 1'b1;
        acc_first_nxt  = (idx_r == '0);
        idx_nxt        = idx_r + idx_t'(1);
        if (idx_r == idx_t'(NUM_LETTERS)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        // Hold the write-back until the output register is free.
        if (!out_valid_r || !out_stall) begin
          hist_req.wr_en       = 1'b1;
          hist_req.addr        = mask_r;
          hist_req.wr_word.tag = epoch_r;
          hist_req.wr_word.cnt = (self_cnt_r < HIST_MAX) ? (self_cnt_r + cnt_t'(1))
                                                         : self_cnt_r;
          out_valid_nxt        = 1'b1;
          out_count_nxt        = total_r;
          state_nxt            = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      epoch_r     <= EPOCH_1ST;
      clr_idx_r   <= '0;
      pending_r   <= 1'b0;
      acc_vld_r   <= 1'b0;
      acc_first_r <= 1'b0;
      out_valid_r <= 1'b0;
      mask_r      <= '0;
      total_r     <= '0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      epoch_r     <= epoch_nxt;
      clr_idx_r   <= clr_idx_nxt;
      pending_r   <= pending_nxt;
      acc_vld_r   <= acc_vld_nxt;
      acc_first_r <= acc_first_nxt;
      out_valid_r <= out_valid_nxt;
      mask_r      <= mask_nxt;
      total_r     <= total_nxt;
      idx_r       <= idx_nxt;
      self_cnt_r  <= self_cnt_nxt;
      out_count_r <= out_count_nxt;
    end
  end

  // A new result appears only out of the write-back step.
  a_result_from_write : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_WRITE))
    else $error("result raised outside write-back");

  // Every read is folded in before the write-back.
  a_reads_drained : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |-> !acc_vld_r)
    else $error("histogram read pending at write-back");

  // Reads never compare against the cleared tag.
  a_epoch_live : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> (epoch_r != EPOCH_CLR))
    else $error("word tag equals cleared tag during reads");

endmodule

>>> rtl/psc_hist.sv
// Single-port prefix histogram with word tags and registered read.
module psc_hist
  import psc_pkg::*;
(
  input  logic      clk,
  input  hist_req_t req,
  input  epoch_t    epoch,
  output cnt_t      rd_value
);

  hist_word_t mem [HIST_DEPTH];
  hist_word_t rd_word_r;
  mask_t      rd_addr_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wr_word;
    end else if (req.rd_en) begin
      rd_word_r <= mem[req.addr];
      rd_addr_r <= req.addr;
    end
  end

  // Stale tag: entry belongs to an earlier word, read its start value.
  always_comb begin
    if (rd_word_r.tag == epoch) begin
      rd_value = rd_word_r.cnt;
    end else begin
      rd_value = (rd_addr_r == '0) ? cnt_t'(1) : '0;
    end
  end

endmodule

>>> rtl/psc_accum.sv
// Shared saturating adder for the running substring total.
module psc_accum
  import psc_pkg::*;
(
  input  total_t total_i,
  input  cnt_t   addend_i,
  output total_t sum_o
);

  logic [TOTAL_W:0] sum_wide;

  assign sum_wide = {1'b0, total_i} + (TOTAL_W + 1)'(addend_i);
  assign sum_o    = sum_wide[TOTAL_W] ? '1 : sum_wide[TOTAL_W-1:0];

endmodule
